// ===== hdl/crcfe_pkg.sv =====
// ----------------------------------------------------------------------------
// crcfe_pkg
// Shared types, constants and the CRC-16/XMODEM byte update for the framer.
// ----------------------------------------------------------------------------
`default_nettype none

package crcfe_pkg;

   localparam logic [15:0] HDR_WORD    = 16'h8668;
   localparam logic [15:0] FTR_WORD    = 16'h55aa;
   localparam logic [15:0] CRC_POLY    = 16'h1021;
   localparam logic [15:0] CRC_TOP     = 16'h8000;
   localparam logic [15:0] LEN_EXTRA   = 16'd3;
   localparam logic [15:0] MAX_PAYLOAD = 16'd65532;

   localparam int unsigned REQ_DATA_W = 32;
   localparam int unsigned RSP_DATA_W = 8;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_DATA  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  packet_type;
      logic [15:0] payload_length;
      logic [7:0]  data_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_end;
      logic       run_last;
   } beat_type;

   typedef enum logic [3:0] {
      ST_NEW,
      ST_HDR_LO,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_TYPE,
      ST_CRC_HI,
      ST_CRC_LO,
      ST_FTR_HI,
      ST_FTR_LO
   } step_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/crcfe_in_stage.sv =====
// ----------------------------------------------------------------------------
// crcfe_in_stage
// Input register: holds one item until the framer has used it up.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfe_in_stage
   import crcfe_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output      logic     in_ready,
   input  wire item_type in_item,
   input  wire logic     take,
   output      logic     hold_valid,
   output      item_type hold_item
);

   logic     valid_ff, valid_in;
   item_type item_ff;

   assign in_ready   = !valid_ff || take;
   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

   always_comb begin
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/crcfe_framer.sv =====
// ----------------------------------------------------------------------------
// crcfe_framer
// Byte sequencer: header, length, type, payload, CRC and footer, one byte
// per cycle while the result register is free, with the running CRC and payload count.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfe_framer
   import crcfe_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     hold_valid,
   input  wire item_type hold_item,
   input  wire logic     slot_free,
   output      logic     emit,
   output      beat_type beat,
   output      logic     take,
   output      logic     busy
);

   step_type    step_ff, step_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] rem_ff, rem_in;
   logic        open_ff, open_in;

   logic [15:0] plen_sat;
   logic [15:0] dlen;
   logic [15:0] rem_dec;

   assign plen_sat = (hold_item.payload_length > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                              : hold_item.payload_length;
   assign dlen     = plen_sat + LEN_EXTRA;
   assign rem_dec  = (rem_ff != 16'd0) ? (rem_ff - 16'd1) : 16'd0;
   assign busy     = (step_ff != ST_NEW);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_NEW;
         crc_ff  <= 16'h0000;
         rem_ff  <= 16'd0;
         open_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         crc_ff  <= crc_in;
         rem_ff  <= rem_in;
         open_ff <= open_in;
      end
   end

   always_comb begin
      step_in = step_ff;
      crc_in  = crc_ff;
      rem_in  = rem_ff;
      open_in = open_ff;
      emit    = 1'b0;
      take    = 1'b0;
      beat    = '0;
      unique case (step_ff)
         ST_NEW: begin
            if (hold_valid) begin
               if (hold_item.kind == KIND_START) begin
                  if (slot_free) begin
                     emit            = 1'b1;
                     beat.frame_byte = HDR_WORD[15:8];
                     crc_in          = 16'h0000;
                     rem_in          = plen_sat;
                     open_in         = 1'b1;
                     step_in         = ST_HDR_LO;
                  end
               end else if (!open_ff) begin
                  // no frame open: drop
                  take = 1'b1;
               end else if (slot_free) begin
                  emit            = 1'b1;
                  beat.frame_byte = hold_item.data_byte;
                  crc_in          = crc_byte(crc_ff, hold_item.data_byte);
                  rem_in          = rem_dec;
                  if (rem_dec == 16'd0) begin
                     step_in = ST_CRC_HI;
                  end else begin
                     beat.run_last = 1'b1;
                     take          = 1'b1;
                  end
               end
            end
         end
         ST_HDR_LO: begin
            if (slot_free) begin
               emit            = 1'b1;
               beat.frame_byte = HDR_WORD[7:0];
               step_in         = ST_LEN_HI;
            end
         end
         ST_LEN_HI: begin
            if (slot_free) begin
               emit            = 1'b1;
               beat.frame_byte = dlen[15:8];
               crc_in          = crc_byte(crc_ff, dlen[15:8]);
               step_in         = ST_LEN_LO;
            end
         end
         ST_LEN_LO: begin
            if (slot_free) begin
               emit            = 1'b1;
               beat.frame_byte = dlen[7:0];
               crc_in          = crc_byte(crc_ff, dlen[7:0]);
               step_in         = ST_TYPE;
            end
         end
         ST_TYPE: begin
            if (slot_free) begin
               emit            = 1'b1;
               beat.frame_byte = hold_item.packet_type;
               crc_in          = crc_byte(crc_ff, hold_item.packet_type);
               if (rem_ff == 16'd0) begin
                  step_in = ST_CRC_HI;
               end else begin
                  beat.run_last = 1'b1;
                  take          = 1'b1;
                  step_in       = ST_NEW;
               end
            end
         end
         ST_CRC_HI: begin
            if (slot_free) begin
               emit            = 1'b1;
               beat.frame_byte = crc_ff[15:8];
               step_in         = ST_CRC_LO;
            end
         end
         ST_CRC_LO: begin
            if (slot_free) begin
               emit            = 1'b1;
               beat.frame_byte = crc_ff[7:0];
               step_in         = ST_FTR_HI;
            end
         end
         ST_FTR_HI: begin
            if (slot_free) begin
               emit            = 1'b1;
               beat.frame_byte = FTR_WORD[15:8];
               step_in         = ST_FTR_LO;
            end
         end
         ST_FTR_LO: begin
            if (slot_free) begin
               emit            = 1'b1;
               beat.frame_byte = FTR_WORD[7:0];
               beat.frame_end  = 1'b1;
               beat.run_last   = 1'b1;
               take            = 1'b1;
               crc_in          = 16'h0000;
               rem_in          = 16'd0;
               open_in         = 1'b0;
               step_in         = ST_NEW;
            end
         end
         default: begin
            step_in = ST_NEW;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/crcfe_out_stage.sv =====
// ----------------------------------------------------------------------------
// crcfe_out_stage
// Result register: one frame byte waiting for transfer on the result side.
// ----------------------------------------------------------------------------
`default_nettype none

module crcfe_out_stage
   import crcfe_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     load,
   input  wire beat_type beat,
   output      logic     slot_free,
   output      logic     out_valid,
   input  wire logic     out_ready,
   output      beat_type out_beat
);

   logic     valid_ff, valid_in;
   beat_type beat_ff;

   assign slot_free = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= beat;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/crc16_frame_encoder_top.sv =====
// ----------------------------------------------------------------------------
// crc16_frame_encoder_top
// Length-prefixed frame builder with CRC-16/XMODEM and fixed header/footer.
// ----------------------------------------------------------------------------
// Path: req item in the input register, framer, byte-wide result register.
// Throughput: one byte per cycle while rsp_tready is high; a payload item gives
//   its byte (then CRC and footer when it closes the frame), a start item its
//   header, length and type (then CRC, footer at zero length), a dropped item none.
// Reset: synchronous, clears both stage valids, sequencer, CRC, count, frame.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_frame_encoder_top
   import crcfe_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output      logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // packet_type, payload_length, data_byte
   input  wire logic                  req_tuser,  // kind
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [RSP_DATA_W-1:0] rsp_tdata,  // frame_byte
   output      logic                  rsp_tlast,  // frame_end
   output      logic                  rsp_tuser   // run_last
);

   item_type req_item;
   item_type hold_item;
   beat_type beat;
   beat_type out_beat;
   logic     hold_valid;
   logic     take;
   logic     emit;
   logic     slot_free;
   logic     busy;

   assign req_item.kind           = kind_type'(req_tuser);
   assign req_item.packet_type    = req_tdata[7:0];
   assign req_item.payload_length = req_tdata[23:8];
   assign req_item.data_byte      = req_tdata[31:24];

   crcfe_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (req_item),
      .take       (take),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   crcfe_framer u_framer (
      .clock      (clock),
      .reset      (reset),
      .hold_valid (hold_valid),
      .hold_item  (hold_item),
      .slot_free  (slot_free),
      .emit       (emit),
      .beat       (beat),
      .take       (take),
      .busy       (busy)
   );

   crcfe_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .load      (emit),
      .beat      (beat),
      .slot_free (slot_free),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_beat  (out_beat)
   );

   assign rsp_tdata = out_beat.frame_byte;
   assign rsp_tlast = out_beat.frame_end;
   assign rsp_tuser = out_beat.run_last;

   // mid-item sequencing needs the item still held
   a_busy_holds_item: assert property (@(posedge clock) disable iff (reset)
      busy |-> hold_valid)
      else $error("framer mid-item without a held item");

   // frame end is always the last byte of its item and is the footer tail
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tuser && (rsp_tdata == FTR_WORD[7:0])))
      else $error("frame end on a byte that is not the footer tail");

   // a new byte only enters when the result register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && rsp_tvalid))
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire
